// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define LPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lps assertion failed");

// checked at every clock edge, reset included
`define LPS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lps assertion failed");

`endif

// File: rtl/lps_pkg.sv
// types, codes and microcode table of the permutation stepper
`timescale 1ns / 1ps

package lps_pkg;

  localparam int LPS_MAX_LEN    = 16;
  localparam int LPS_ELEM_WIDTH = 32;

  // fixed field widths of the stream ports
  localparam int OPCODE_W  = 2;
  localparam int LDIDX_W   = 4;
  localparam int LDVAL_W   = 32;
  localparam int POS_W     = 4;
  localparam int ELEM_W    = 32;
  localparam int LEN_W     = 5;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_NEXT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PREV = 2'd2;

  localparam int UPC_W = 4;

  // microcode step addresses
  localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] U_P_RD   = 4'd1;
  localparam logic [UPC_W-1:0] U_P_TST  = 4'd2;
  localparam logic [UPC_W-1:0] U_PIV    = 4'd3;
  localparam logic [UPC_W-1:0] U_S_RD   = 4'd4;
  localparam logic [UPC_W-1:0] U_S_TST  = 4'd5;
  localparam logic [UPC_W-1:0] U_SW_I   = 4'd6;
  localparam logic [UPC_W-1:0] U_SW_J   = 4'd7;
  localparam logic [UPC_W-1:0] U_WRAP   = 4'd8;
  localparam logic [UPC_W-1:0] U_R_RD   = 4'd9;
  localparam logic [UPC_W-1:0] U_R_WI   = 4'd10;
  localparam logic [UPC_W-1:0] U_R_WJ   = 4'd11;
  localparam logic [UPC_W-1:0] U_E_INIT = 4'd12;
  localparam logic [UPC_W-1:0] U_E_RD   = 4'd13;
  localparam logic [UPC_W-1:0] U_E_PUSH = 4'd14;

  // branch conditions
  localparam logic [2:0] C_TRUE    = 3'd0;
  localparam logic [2:0] C_START   = 3'd1;
  localparam logic [2:0] C_J0      = 3'd2;
  localparam logic [2:0] C_BEF_AB  = 3'd3;
  localparam logic [2:0] C_BEF_PB  = 3'd4;
  localparam logic [2:0] C_I_GE_J  = 3'd5;
  localparam logic [2:0] C_I_EQ_N  = 3'd6;
  localparam logic [2:0] C_BLOCKED = 3'd7;

  // memory write sources
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_I_B  = 2'd1;
  localparam logic [1:0] WR_J_A  = 2'd2;
  localparam logic [1:0] WR_J_PV = 2'd3;

  // pointer updates
  localparam logic [1:0] I_HOLD = 2'd0;
  localparam logic [1:0] I_JM1  = 2'd1;
  localparam logic [1:0] I_INC  = 2'd2;
  localparam logic [1:0] I_ZERO = 2'd3;

  localparam logic [1:0] J_HOLD = 2'd0;
  localparam logic [1:0] J_LAST = 2'd1;
  localparam logic [1:0] J_DEC  = 2'd2;

  localparam logic [1:0] ADV_HOLD = 2'd0;
  localparam logic [1:0] ADV_SET  = 2'd1;
  localparam logic [1:0] ADV_CLR  = 2'd2;

  localparam logic RA_I   = 1'b0;
  localparam logic RA_JM1 = 1'b1;

  typedef struct packed {
    logic [2:0]       cond;
    logic [UPC_W-1:0] t_true;
    logic [UPC_W-1:0] t_false;
    logic             gate;     // ops only when the branch is not taken
    logic             rd_en;
    logic             rd_a_sel;
    logic [1:0]       wr;
    logic [1:0]       i_op;
    logic [1:0]       j_op;
    logic             pv_ld;
    logic [1:0]       adv_op;
    logic             push;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic j0;
    logic bef_ab;
    logic bef_pb;
    logic i_ge_j;
    logic i_eq_n;
    logic blocked;
  } stat_t;

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] a);
    ctrl_t w;
    w = '0;
    case (a)
      U_IDLE: begin
        w.cond = C_START; w.t_true = U_P_RD; w.t_false = U_IDLE;
        w.j_op = J_LAST;
      end
      // pivot scan from the tail
      U_P_RD: begin
        w.cond = C_J0; w.t_true = U_WRAP; w.t_false = U_P_TST; w.gate = 1'b1;
        w.rd_en = 1'b1; w.rd_a_sel = RA_JM1;
      end
      U_P_TST: begin
        w.cond = C_BEF_AB; w.t_true = U_PIV; w.t_false = U_P_RD; w.gate = 1'b1;
        w.j_op = J_DEC;
      end
      U_PIV: begin
        w.t_true = U_S_RD; w.t_false = U_S_RD;
        w.i_op = I_JM1; w.j_op = J_LAST; w.pv_ld = 1'b1;
      end
      // swap partner scan
      U_S_RD: begin
        w.t_true = U_S_TST; w.t_false = U_S_TST;
        w.rd_en = 1'b1;
      end
      U_S_TST: begin
        w.cond = C_BEF_PB; w.t_true = U_SW_I; w.t_false = U_S_RD; w.gate = 1'b1;
        w.j_op = J_DEC;
      end
      U_SW_I: begin
        w.t_true = U_SW_J; w.t_false = U_SW_J;
        w.wr = WR_I_B;
      end
      U_SW_J: begin
        w.t_true = U_R_RD; w.t_false = U_R_RD;
        w.wr = WR_J_PV; w.i_op = I_INC; w.j_op = J_LAST; w.adv_op = ADV_SET;
      end
      U_WRAP: begin
        w.t_true = U_R_RD; w.t_false = U_R_RD;
        w.i_op = I_ZERO; w.j_op = J_LAST; w.adv_op = ADV_CLR;
      end
      // suffix reversal, one pair per pass
      U_R_RD: begin
        w.cond = C_I_GE_J; w.t_true = U_E_INIT; w.t_false = U_R_WI; w.gate = 1'b1;
        w.rd_en = 1'b1; w.rd_a_sel = RA_I;
      end
      U_R_WI: begin
        w.t_true = U_R_WJ; w.t_false = U_R_WJ;
        w.wr = WR_I_B;
      end
      U_R_WJ: begin
        w.t_true = U_R_RD; w.t_false = U_R_RD;
        w.wr = WR_J_A; w.i_op = I_INC; w.j_op = J_DEC;
      end
      // emit the active range
      U_E_INIT: begin
        w.t_true = U_E_RD; w.t_false = U_E_RD;
        w.i_op = I_ZERO;
      end
      U_E_RD: begin
        w.cond = C_I_EQ_N; w.t_true = U_IDLE; w.t_false = U_E_PUSH; w.gate = 1'b1;
        w.rd_en = 1'b1; w.rd_a_sel = RA_I;
      end
      U_E_PUSH: begin
        w.cond = C_BLOCKED; w.t_true = U_E_PUSH; w.t_false = U_E_RD; w.gate = 1'b1;
        w.push = 1'b1; w.i_op = I_INC;
      end
      default: begin
        w.t_true = U_IDLE; w.t_false = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/lps_seq.sv
// microcode sequencer: step counter, control rom and branch logic
`timescale 1ns / 1ps

module lps_seq import lps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  op_en,
  output logic  idle
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             cond_true;

  assign ctrl = ucode(upc);

  always_comb begin
    case (ctrl.cond)
      C_TRUE:    cond_true = 1'b1;
      C_START:   cond_true = stat.start;
      C_J0:      cond_true = stat.j0;
      C_BEF_AB:  cond_true = stat.bef_ab;
      C_BEF_PB:  cond_true = stat.bef_pb;
      C_I_GE_J:  cond_true = stat.i_ge_j;
      C_I_EQ_N:  cond_true = stat.i_eq_n;
      C_BLOCKED: cond_true = stat.blocked;
      default:   cond_true = 1'b0;
    endcase
  end

  assign op_en    = !ctrl.gate || !cond_true;
  assign upc_next = cond_true ? ctrl.t_true : ctrl.t_false;
  assign idle     = (upc == U_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: rtl/lps_dpath.sv
// datapath: element memory, pointers, comparator and output register
`timescale 1ns / 1ps

module lps_dpath import lps_pkg::*; #(
  parameter int MAX_LEN    = LPS_MAX_LEN,
  parameter int ELEM_WIDTH = LPS_ELEM_WIDTH,
  parameter int CNT_W      = $clog2(MAX_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic                op_en,
  input  logic                start,
  input  logic                start_nxt,
  input  logic                load_en,
  input  logic [LDIDX_W-1:0]  load_index,
  input  logic signed [LDVAL_W-1:0] load_value,
  input  logic [CNT_W-1:0]    n,
  input  logic                out_ready,
  output stat_t               stat,
  output logic                out_valid,
  output logic [POS_W-1:0]    out_pos,
  output logic signed [ELEM_W-1:0] out_elem,
  output logic                out_adv,
  output logic                out_last
);

  localparam int IDX_W = $clog2(MAX_LEN);

  logic [ELEM_WIDTH-1:0] mem [MAX_LEN];

  logic [CNT_W-1:0]             i;
  logic [CNT_W-1:0]             j;
  logic signed [ELEM_WIDTH-1:0] rd_a;
  logic signed [ELEM_WIDTH-1:0] rd_b;
  logic signed [ELEM_WIDTH-1:0] pv;
  logic                         adv;
  logic                         nxt;

  logic [CNT_W-1:0]      j_m1;
  logic [CNT_W-1:0]      n_last;
  logic [IDX_W-1:0]      addr_a;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic                  load_ok;

  assign j_m1    = j - 1'b1;
  assign n_last  = n - 1'b1;
  assign addr_a  = (ctrl.rd_a_sel == RA_JM1) ? j_m1[IDX_W-1:0] : i[IDX_W-1:0];
  assign load_ok = int'(load_index) < MAX_LEN;

  // status back to the sequencer
  always_comb begin
    stat.start   = start;
    stat.j0      = (j == '0);
    stat.bef_ab  = nxt ? (rd_a < rd_b) : (rd_b < rd_a);
    stat.bef_pb  = nxt ? (pv < rd_b) : (rd_b < pv);
    stat.i_ge_j  = (i >= j);
    stat.i_eq_n  = (i == n);
    stat.blocked = out_valid && !out_ready;
  end

  // single write port shared by loads and the step program
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i[IDX_W-1:0];
    wr_data = rd_b;
    if (load_en) begin
      wr_en   = load_ok;
      wr_addr = IDX_W'(load_index);
      wr_data = ELEM_WIDTH'(load_value);
    end else if (op_en) begin
      case (ctrl.wr)
        WR_I_B: begin
          wr_en   = 1'b1;
          wr_addr = i[IDX_W-1:0];
          wr_data = rd_b;
        end
        WR_J_A: begin
          wr_en   = 1'b1;
          wr_addr = j[IDX_W-1:0];
          wr_data = rd_a;
        end
        WR_J_PV: begin
          wr_en   = 1'b1;
          wr_addr = j[IDX_W-1:0];
          wr_data = pv;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en && op_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[j[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i   <= '0;
      j   <= '0;
      adv <= 1'b0;
      nxt <= 1'b0;
    end else begin
      if (start) begin
        nxt <= start_nxt;
      end
      if (op_en) begin
        case (ctrl.i_op)
          I_JM1:   i <= j_m1;
          I_INC:   i <= i + 1'b1;
          I_ZERO:  i <= '0;
          default: i <= i;
        endcase
        case (ctrl.j_op)
          J_LAST:  j <= n_last;
          J_DEC:   j <= j_m1;
          default: j <= j;
        endcase
        case (ctrl.adv_op)
          ADV_SET: adv <= 1'b1;
          ADV_CLR: adv <= 1'b0;
          default: adv <= adv;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pv_ld && op_en) begin
      pv <= rd_a;
    end
  end

  // output register, parts the sequencer from the downstream side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push && op_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && op_en) begin
      out_pos  <= POS_W'(i);
      out_elem <= ELEM_W'(rd_a);
      out_adv  <= adv;
      out_last <= (i == n_last);
    end
  end

endmodule

// File: rtl/lexicographic_permutation_step.sv
// top level of the lexicographic permutation stepper
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: load_index, load_value; tuser: opcode
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: position, element; tuser: advanced; tlast
//  cfg       in   cfg_valid / cfg_ready          cfg_data: length
//
// a step runs a microcode program over an element memory with registered
// reads and one write port: a pivot scan from the tail, a partner scan, a
// reversal of the suffix one pair per pass and the emit of every element
// in the active range
// reset clears the sequencer and the output valid flag and sets length to 16;
// array contents stay undefined until loaded
// a stalled output beat holds the program in its emit step
`timescale 1ns / 1ps

module lexicographic_permutation_step import lps_pkg::*; #(
  parameter int MAX_LEN    = LPS_MAX_LEN,
  parameter int ELEM_WIDTH = LPS_ELEM_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // load_index, load_value, zero pad
  input  logic [OPCODE_W-1:0]  s_axis_tuser,   // opcode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // position, element, zero pad
  output logic                 m_axis_tuser,   // advanced
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LEN_W-1:0]     cfg_data        // length
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [LEN_W-1:0]          length;
  logic [CNT_W-1:0]          n;
  logic                      idle;
  logic                      accept;
  logic                      start;
  logic                      load_en;
  logic [OPCODE_W-1:0]       opcode;
  logic [LDIDX_W-1:0]        load_index;
  logic signed [LDVAL_W-1:0] load_value;
  ctrl_t                     ctrl;
  stat_t                     stat;
  logic                      op_en;
  logic [POS_W-1:0]          out_pos;
  logic signed [ELEM_W-1:0]  out_elem;

  assign opcode     = s_axis_tuser;
  assign load_index = s_axis_tdata[LDIDX_W-1:0];
  assign load_value = s_axis_tdata[LDIDX_W +: LDVAL_W];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length <= cfg_data;
    end
  end

  // active length, clamped to 1..MAX_LEN
  always_comb begin
    if (length == '0) begin
      n = CNT_W'(1);
    end else if (int'(length) > MAX_LEN) begin
      n = CNT_W'(MAX_LEN);
    end else begin
      n = CNT_W'(length);
    end
  end

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && idle;
  assign start         = accept && ((opcode == OP_NEXT) || (opcode == OP_PREV));
  assign load_en       = accept && (opcode == OP_LOAD);

  lps_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .ctrl  (ctrl),
    .op_en (op_en),
    .idle  (idle)
  );

  lps_dpath #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .op_en      (op_en),
    .start      (start),
    .start_nxt  (opcode == OP_NEXT),
    .load_en    (load_en),
    .load_index (load_index),
    .load_value (load_value),
    .n          (n),
    .out_ready  (m_axis_tready),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_pos    (out_pos),
    .out_elem   (out_elem),
    .out_adv    (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = M_TDATA_W'({out_elem, out_pos});

endmodule

// File: rtl/lps_checker.sv
// port-level checker for the permutation stepper, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lps_checker import lps_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [OPCODE_W-1:0]  s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 m_axis_tlast
);

  // a stalled output beat keeps its payload
  `LPS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // a step command closes the input until its run is out
  `LPS_ASSERT(a_step_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_NEXT || s_axis_tuser == OP_PREV) |=> !s_axis_tready)

  // no new input between beats of one run
  `LPS_ASSERT(a_run_busy, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)

  // out of reset the block is idle with nothing to send
  `LPS_ASSERT_ALWAYS(a_reset_idle, rst |=> s_axis_tready && !m_axis_tvalid)

endmodule

bind lexicographic_permutation_step lps_checker u_lps_checker (.*);
